@@ design/safety_input_stage_checker_core_defines.svh @@
// Assertion macros shared by the safety input stage checker project.
// Included by the checker file; depends on nothing else.
`ifndef SAFETY_INPUT_STAGE_CHECKER_CORE_DEFINES_SVH
`define SAFETY_INPUT_STAGE_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SISC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sisc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SISC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sisc assertion failed");

`endif

@@ design/sisc_pkg.sv @@
// Package for the safety input stage checker: payload structs, codes and
// register reset values. Used by the core and its checker; no dependencies.
`default_nettype none

package sisc_pkg;

  // Default number of stages and fixed register geometry.
  localparam int MAX_STAGES_DEF = 8;
  localparam int LEVEL_PAIRS    = 8;   // stage pairs held in expected_levels
  localparam int PAIR_IDX_W     = 3;
  localparam int CFG_DATA_W     = 20;
  localparam int CFG_IDX_W      = 2;
  localparam int LEVELS_W       = 16;
  localparam int COUNT_CFG_W    = 4;
  localparam int STABLE_W       = 16;
  localparam int TIMEOUT_W      = 20;
  localparam int STAGE_OUT_W    = 4;

  // Register reset values.
  localparam logic [LEVELS_W-1:0]    LEVELS_RST  = 16'd11822;
  localparam logic [COUNT_CFG_W-1:0] COUNT_RST   = 4'd7;
  localparam logic [STABLE_W-1:0]    STABLE_RST  = 16'd25;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST = 20'd4500;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_LEVELS = 2'd0,
    CFG_STAGE_COUNT     = 2'd1,
    CFG_STABLE_TICKS    = 2'd2,
    CFG_TIMEOUT_TICKS   = 2'd3
  } cfg_reg_e;

  // Per-tick status codes.
  typedef enum logic [2:0] {
    ST_WAIT     = 3'd0,
    ST_PASSED   = 3'd1,
    ST_ALL      = 3'd2,
    ST_READFAIL = 3'd3,
    ST_TIMEOUT  = 3'd4,
    ST_HOLD     = 3'd5
  } status_e;

  // Overall run outcome.
  typedef enum logic [1:0] {
    RUN_GOING = 2'd0,
    RUN_PASS  = 2'd1,
    RUN_FAIL  = 2'd2
  } run_e;

  typedef struct packed {
    logic estop_level;
    logic enable_level;
    logic sample_valid;
  } in_item_t;

  typedef struct packed {
    logic [STAGE_OUT_W-1:0] current_stage;
    status_e                status;
    run_e                   final_result;
    logic                   levels_changed;
    logic                   levels_match;
  } out_item_t;

endpackage

`default_nettype wire

@@ design/safety_input_stage_checker_core.sv @@
// Safety input stage checker core: walks expected e-stop/enable level pairs
// one poll tick at a time. Depends on sisc_pkg.
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i, in_ready_o, in_data_i         | sink
//  out      | out_valid_o, out_ready_i, out_data_o      | source
//  cfg      | cfg_we_i, cfg_index_i, cfg_data_i         | sink
//
// Each tick yields one result, which appears in the result
// register the cycle after its transfer. A new tick is taken every cycle while
// the result register is empty or being drained, so the rate is one per cycle,
// set by the single stage update. Reset clears all run state and loads the
// register defaults. A stalled output blocks input only while the result
// register is full and not taken.
`default_nettype none

module safety_input_stage_checker_core
  import sisc_pkg::*;
#(
  parameter int MAX_STAGES = MAX_STAGES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int StageW = $clog2(MAX_STAGES + 1);

  // Configuration registers.
  logic [LEVELS_W-1:0]    levels_q;
  logic [COUNT_CFG_W-1:0] count_q;
  logic [STABLE_W-1:0]    stable_q;
  logic [TIMEOUT_W-1:0]   timeout_q;

  // Run state.
  logic [StageW-1:0]    stage_q, stage_d;
  logic [StageW-1:0]    held_q, held_d;
  logic [TIMEOUT_W-1:0] ticks_q, ticks_d;
  logic [STABLE_W-1:0]  run_cnt_q, run_cnt_d;
  logic                 in_run_q, in_run_d;
  logic                 have_prior_q, have_prior_d;
  logic                 prior_estop_q, prior_estop_d;
  logic                 prior_enable_q, prior_enable_d;
  run_e                 outcome_q, outcome_d;

  // Result register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic                  accept;
  logic [StageW-1:0]     eff_count;
  logic [PAIR_IDX_W-1:0] pair_idx;
  logic [1:0]            pair;
  logic                  changed;
  logic                  match;
  logic [STABLE_W-1:0]   run_cnt_nxt;
  logic                  stage_pass;
  logic [StageW:0]       next_stage;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q  <= LEVELS_RST;
      count_q   <= COUNT_RST;
      stable_q  <= STABLE_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_EXPECTED_LEVELS: levels_q  <= cfg_data_i[LEVELS_W-1:0];
        CFG_STAGE_COUNT:     count_q   <= cfg_data_i[COUNT_CFG_W-1:0];
        CFG_STABLE_TICKS:    stable_q  <= cfg_data_i[STABLE_W-1:0];
        CFG_TIMEOUT_TICKS:   timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage count clamped into one to MAX_STAGES.
  always_comb begin
    if (count_q == '0) begin
      eff_count = StageW'(1);
    end else if (int'(count_q) > MAX_STAGES) begin
      eff_count = StageW'(MAX_STAGES);
    end else begin
      eff_count = StageW'(count_q);
    end
  end

  // Expected pair for the current stage; stages past the register read as low.
  assign pair_idx = PAIR_IDX_W'(stage_q);
  always_comb begin
    if (int'(stage_q) < LEVEL_PAIRS) begin
      pair = levels_q[{pair_idx, 1'b0} +: 2];
    end else begin
      pair = 2'b00;
    end
  end

  assign changed = !have_prior_q || (in_data_i.estop_level != prior_estop_q) ||
                   (in_data_i.enable_level != prior_enable_q);
  assign match   = (in_data_i.estop_level == pair[0]) && (in_data_i.enable_level == pair[1]);

  // Match run counter: restarts at zero on the first matching tick, saturates.
  always_comb begin
    if (!in_run_q) begin
      run_cnt_nxt = '0;
    end else if (run_cnt_q != '1) begin
      run_cnt_nxt = run_cnt_q + 1'b1;
    end else begin
      run_cnt_nxt = run_cnt_q;
    end
  end

  assign stage_pass = match && (run_cnt_nxt >= stable_q);
  assign next_stage = {1'b0, stage_q} + 1'b1;

  // Per-tick update of the run state and the result.
  always_comb begin
    stage_d        = stage_q;
    held_d         = held_q;
    ticks_d        = ticks_q;
    run_cnt_d      = run_cnt_q;
    in_run_d       = in_run_q;
    have_prior_d   = have_prior_q;
    prior_estop_d  = prior_estop_q;
    prior_enable_d = prior_enable_q;
    outcome_d      = outcome_q;

    out_d.current_stage  = STAGE_OUT_W'(stage_q);
    out_d.status         = ST_WAIT;
    out_d.final_result   = outcome_q;
    out_d.levels_changed = 1'b0;
    out_d.levels_match   = 1'b0;

    if (outcome_q != RUN_GOING) begin
      out_d.current_stage = STAGE_OUT_W'(held_q);
      out_d.status        = ST_HOLD;
    end else if (ticks_q >= timeout_q) begin
      out_d.status       = ST_TIMEOUT;
      outcome_d          = RUN_FAIL;
      out_d.final_result = RUN_FAIL;
      held_d             = stage_q;
    end else if (!in_data_i.sample_valid) begin
      out_d.status       = ST_READFAIL;
      outcome_d          = RUN_FAIL;
      out_d.final_result = RUN_FAIL;
      held_d             = stage_q;
    end else begin
      out_d.levels_changed = changed;
      out_d.levels_match   = match;
      if (stage_pass) begin
        // Stage passed: move on and clear the per-stage state.
        stage_d        = StageW'(next_stage);
        ticks_d        = '0;
        run_cnt_d      = '0;
        in_run_d       = 1'b0;
        have_prior_d   = 1'b0;
        prior_estop_d  = 1'b0;
        prior_enable_d = 1'b0;
        if (next_stage >= {1'b0, eff_count}) begin
          out_d.status        = ST_ALL;
          outcome_d           = RUN_PASS;
          out_d.final_result  = RUN_PASS;
          out_d.current_stage = STAGE_OUT_W'(eff_count);
          held_d              = eff_count;
        end else begin
          out_d.status = ST_PASSED;
        end
      end else begin
        prior_estop_d  = in_data_i.estop_level;
        prior_enable_d = in_data_i.enable_level;
        have_prior_d   = 1'b1;
        if (ticks_q != '1) begin
          ticks_d = ticks_q + 1'b1;
        end
        in_run_d  = match;
        run_cnt_d = match ? run_cnt_nxt : '0;
      end
    end
  end

  // Output register valid: set on a transfer in, cleared when taken.
  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q        <= '0;
      held_q         <= '0;
      ticks_q        <= '0;
      run_cnt_q      <= '0;
      in_run_q       <= 1'b0;
      have_prior_q   <= 1'b0;
      prior_estop_q  <= 1'b0;
      prior_enable_q <= 1'b0;
      outcome_q      <= RUN_GOING;
      out_valid_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        stage_q        <= stage_d;
        held_q         <= held_d;
        ticks_q        <= ticks_d;
        run_cnt_q      <= run_cnt_d;
        in_run_q       <= in_run_d;
        have_prior_q   <= have_prior_d;
        prior_estop_q  <= prior_estop_d;
        prior_enable_q <= prior_enable_d;
        outcome_q      <= outcome_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

@@ design/sisc_checker.sv @@
// Port-level checker for the safety input stage checker core, bound to it
// below. Depends on sisc_pkg and safety_input_stage_checker_core_defines.svh.
`default_nettype none

`include "safety_input_stage_checker_core_defines.svh"

module sisc_checker
  import sisc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  logic out_xfer;
  logic out_stall;
  logic st_hold;
  logic st_fail;
  logic st_live;
  logic run_done;
  logic run_failed;

  assign out_xfer   = out_valid_o && out_ready_i;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign st_hold    = out_data_o.status == ST_HOLD;
  assign st_fail    = (out_data_o.status == ST_READFAIL) || (out_data_o.status == ST_TIMEOUT);
  assign st_live    = (out_data_o.status == ST_WAIT) || (out_data_o.status == ST_PASSED) ||
                      (out_data_o.status == ST_ALL);
  assign run_done   = out_data_o.final_result != RUN_GOING;
  assign run_failed = out_data_o.final_result == RUN_FAIL;

  // A result that is stalled stays offered unchanged.
  `SISC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  // Holding status only appears once the run has an outcome.
  `SISC_ASSERT_IMP(a_hold_final, clk_i, rst_ni, out_xfer && st_hold, run_done)

  // Failures report a failed run.
  `SISC_ASSERT_IMP(a_fail_final, clk_i, rst_ni, out_xfer && st_fail, run_failed)

  // A level match is only reported on ticks whose sample was looked at.
  `SISC_ASSERT_IMP(a_match_live, clk_i, rst_ni, out_xfer && out_data_o.levels_match, st_live)

endmodule

bind safety_input_stage_checker_core sisc_checker u_sisc_checker (.*);

`default_nettype wire

@@ tb/tb_safety_input_stage_checker_core.sv @@
// Testbench for safety_input_stage_checker_core: a directed table, then random level
// sequences, each result checked against a stage-walk predictor. Depends on sisc_pkg.
`timescale 1ns / 100ps
`default_nettype none

module tb_safety_input_stage_checker_core;
  import sisc_pkg::*;

  localparam int PRESSURE_CYCLES = 40;
  localparam int PHASE_TICKS     = 150;
  localparam int NUM_PHASES      = 6;
  localparam int HOLD_TICKS      = 40;

  // Ways in which the single run of this reset is brought to its end.
  typedef enum int {
    END_TIMEOUT_ZERO,
    END_READ_FAIL,
    END_COUNT_LOWERED,
    END_TIMEOUT_RUN
  } end_mode_e;

  // One row of the directed table: a register write or a tick, with a typed
  // report where the outcome is plain to see.
  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_e              reg_sel;
    logic [CFG_DATA_W-1:0] value;
    in_item_t              tick;
    logic                  typed;
    out_item_t             report;
  } dir_row_t;

  // Tick bits are {estop, enable, valid}. Rows start from the reset defaults.
  localparam dir_row_t DIRECTED [24] = '{
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b101, 1'b1, '{4'd0, ST_WAIT, RUN_GOING, 1'b1, 1'b0}},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b011, 1'b1, '{4'd0, ST_WAIT, RUN_GOING, 1'b1, 1'b1}},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b011, 1'b1, '{4'd0, ST_WAIT, RUN_GOING, 1'b0, 1'b1}},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b001, 1'b1, '{4'd0, ST_WAIT, RUN_GOING, 1'b1, 1'b0}},
    '{1'b1, CFG_STABLE_TICKS,    20'd0, 3'b000, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b011, 1'b1,
      '{4'd0, ST_PASSED, RUN_GOING, 1'b1, 1'b1}},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b111, 1'b1,
      '{4'd1, ST_PASSED, RUN_GOING, 1'b1, 1'b1}},
    '{1'b1, CFG_STABLE_TICKS,    20'd65535, 3'b000, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b011, 1'b1, '{4'd2, ST_WAIT, RUN_GOING, 1'b1, 1'b1}},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b011, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b111, 1'b0, '0},
    '{1'b1, CFG_EXPECTED_LEVELS, 20'hFFFF, 3'b000, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b111, 1'b0, '0},
    '{1'b1, CFG_STABLE_TICKS,    20'd1, 3'b000, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b111, 1'b0, '0},
    '{1'b1, CFG_STAGE_COUNT,     20'd15, 3'b000, 1'b0, '0},
    '{1'b1, CFG_TIMEOUT_TICKS,   20'hFFFFF, 3'b000, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b001, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b101, 1'b0, '0},
    '{1'b1, CFG_EXPECTED_LEVELS, 20'h0000, 3'b000, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b001, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b011, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b111, 1'b0, '0},
    '{1'b0, CFG_EXPECTED_LEVELS, 20'd0, 3'b001, 1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Register copies and run state of the stage-walk predictor.
  logic [LEVELS_W-1:0]    lvl_map        = LEVELS_RST;
  logic [COUNT_CFG_W-1:0] cnt_cfg        = COUNT_RST;
  logic [STABLE_W-1:0]    stable_cfg     = STABLE_RST;
  logic [TIMEOUT_W-1:0]   timeout_cfg    = TIMEOUT_RST;
  logic [3:0]             stage_idx      = '0;
  logic [TIMEOUT_W-1:0]   ticks_in_stage = '0;
  logic [STABLE_W-1:0]    match_len      = '0;
  logic                   matching       = 1'b0;
  logic                   seen_sample    = 1'b0;
  logic                   last_estop     = 1'b0;
  logic                   last_enable    = 1'b0;
  run_e                   outcome        = RUN_GOING;
  logic [3:0]             frozen_stage   = '0;

  out_item_t stage_reports_q[$];
  int        err_cnt  = 0;
  bit        gaps_on  = 1'b1;
  bit        quiet    = 1'b0;
  bit        hold_req = 1'b0;

  safety_input_stage_checker_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stage count as the block uses it: zero acts as one, large values clamp.
  function automatic int eff_stages();
    if (cnt_cfg == '0) return 1;
    if (int'(cnt_cfg) > MAX_STAGES_DEF) return MAX_STAGES_DEF;
    return int'(cnt_cfg);
  endfunction

  // Expected pair of the current stage: bit 0 e-stop, bit 1 enable.
  function automatic logic [1:0] stage_pair();
    if (int'(stage_idx) < LEVEL_PAIRS) return lvl_map[2*stage_idx +: 2];
    return 2'b00;
  endfunction

  function automatic in_item_t level_tick(logic [1:0] pair);
    in_item_t t;
    t.estop_level  = pair[0];
    t.enable_level = pair[1];
    t.sample_valid = 1'b1;
    return t;
  endfunction

  // Advance the stage walk by one tick and return the report it produces.
  function automatic out_item_t predict_stage_report(in_item_t t);
    out_item_t  r;
    logic [3:0] cur;
    logic [1:0] pair;
    logic       hit;
    r      = '0;
    cur    = stage_idx;
    r.status = ST_WAIT;
    if (outcome != RUN_GOING) begin
      cur      = frozen_stage;
      r.status = ST_HOLD;
    end else if (ticks_in_stage >= timeout_cfg) begin
      // The timeout is checked before the sample is looked at.
      r.status     = ST_TIMEOUT;
      outcome      = RUN_FAIL;
      frozen_stage = cur;
    end else if (!t.sample_valid) begin
      r.status     = ST_READFAIL;
      outcome      = RUN_FAIL;
      frozen_stage = cur;
    end else begin
      pair = stage_pair();
      if (!seen_sample || t.estop_level != last_estop || t.enable_level != last_enable) begin
        r.levels_changed = 1'b1;
        last_estop       = t.estop_level;
        last_enable      = t.enable_level;
        seen_sample      = 1'b1;
      end
      hit = (t.estop_level == pair[0]) && (t.enable_level == pair[1]);
      r.levels_match = hit;
      if (ticks_in_stage != '1) ticks_in_stage++;
      if (hit) begin
        // The first matching tick counts as zero.
        if (!matching) begin
          matching  = 1'b1;
          match_len = '0;
        end else if (match_len != '1) begin
          match_len++;
        end
        if (match_len >= stable_cfg) begin
          stage_idx      = cur + 4'd1;
          ticks_in_stage = '0;
          match_len      = '0;
          matching       = 1'b0;
          seen_sample    = 1'b0;
          last_estop     = 1'b0;
          last_enable    = 1'b0;
          if (int'(stage_idx) >= eff_stages()) begin
            r.status     = ST_ALL;
            outcome      = RUN_PASS;
            cur          = 4'(eff_stages());
            frozen_stage = cur;
          end else begin
            r.status = ST_PASSED;
          end
        end
      end else begin
        matching  = 1'b0;
        match_len = '0;
      end
    end
    r.current_stage = cur;
    r.final_result  = outcome;
    return r;
  endfunction

  // Offer one tick, wait for its transfer, then record the report it causes.
  task automatic send_tick(input in_item_t tick, input bit typed, input out_item_t typed_rep);
    out_item_t rep;
    in_data_i  <= tick;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rep = predict_stage_report(tick);
    stage_reports_q.push_back(typed ? typed_rep : rep);
    if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Registers change only once every pending report has come back.
  task automatic write_cfg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    in_valid_i <= 1'b0;
    while (stage_reports_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_EXPECTED_LEVELS: lvl_map     = val[LEVELS_W-1:0];
      CFG_STAGE_COUNT:     cnt_cfg     = val[COUNT_CFG_W-1:0];
      CFG_STABLE_TICKS:    stable_cfg  = val[STABLE_W-1:0];
      CFG_TIMEOUT_TICKS:   timeout_cfg = val[TIMEOUT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Result side: random stalls, one long hold-off on request, none at the end.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Compare every report transfer with the oldest predicted report.
  initial begin
    out_item_t got;
    out_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (stage_reports_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("report with none pending: stage=%0d status=%0d",
                                      got.current_stage, got.status);
        end else begin
          want = stage_reports_q.pop_front();
          if (got.current_stage !== want.current_stage || got.status !== want.status ||
              got.final_result !== want.final_result ||
              got.levels_changed !== want.levels_changed ||
              got.levels_match !== want.levels_match) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("report mismatch: got stage=%0d status=%0d result=%0d chg=%b match=%b",
                       got.current_stage, got.status, got.final_result,
                       got.levels_changed, got.levels_match);
              $display("                 want stage=%0d status=%0d result=%0d chg=%b match=%b",
                       want.current_stage, want.status, want.final_result,
                       want.levels_changed, want.levels_match);
            end
          end
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus: directed table, random phases, one way of ending the run, hold.
  initial begin
    int         sent;
    int         len;
    int         lo;
    logic [1:0] pair;
    logic [1:0] want;
    bit         guarded;
    bit         follow;
    logic [3:0] start_idx;
    in_item_t   t;
    end_mode_e  mode;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) write_cfg(DIRECTED[i].reg_sel, DIRECTED[i].value);
      else send_tick(DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].report);
    end

    // Each phase lets at most one stage pass, and never the last one.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      lo = (int'(stage_idx) + 2 > MAX_STAGES_DEF) ? MAX_STAGES_DEF : int'(stage_idx) + 2;
      write_cfg(CFG_EXPECTED_LEVELS, (ph == 0) ? 20'hFFFF :
                                     (ph == 1) ? 20'h0000 : 20'($urandom_range(0, 16'hFFFF)));
      write_cfg(CFG_STAGE_COUNT, (ph == 0) ? 20'd15 : 20'($urandom_range(lo, 15)));
      case (ph)
        0: write_cfg(CFG_STABLE_TICKS, 20'd0);
        1: write_cfg(CFG_STABLE_TICKS, 20'd1);
        3: write_cfg(CFG_STABLE_TICKS, 20'd65535);
        4: write_cfg(CFG_STABLE_TICKS, 20'($urandom_range(2, 20)));
        5: write_cfg(CFG_STABLE_TICKS, 20'($urandom_range(0, 30)));
        default: write_cfg(CFG_STABLE_TICKS, 20'($urandom_range(2, 10)));
      endcase
      write_cfg(CFG_TIMEOUT_TICKS, (ph == 2) ? 20'hFFFFF : 20'($urandom_range(4096, 20'hFFFFF)));
      gaps_on   = ($urandom_range(0, 2) != 0);
      start_idx = stage_idx;
      if (ph == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_TICKS) begin
        // Mostly runs that track the expected pair, the rest random levels.
        follow = ($urandom_range(0, 3) != 0);
        if (follow) begin
          len = ($urandom_range(0, 1) == 0) ? int'(stable_cfg) + 1 + $urandom_range(0, 2)
                                            : $urandom_range(1, int'(stable_cfg) + 1);
        end else begin
          len = $urandom_range(1, 6);
        end
        if (len > 60) len = 60;
        repeat (len) begin
          want    = stage_pair();
          guarded = (stage_idx != start_idx) || (int'(stage_idx) + 1 >= eff_stages());
          pair    = follow ? want : 2'($urandom_range(0, 3));
          if (guarded && pair == want) pair = want ^ 2'($urandom_range(1, 3));
          send_tick(level_tick(pair), 1'b0, '0);
          sent++;
        end
      end
    end

    // End the run, then check that the final status holds.
    quiet = 1'b1;
    mode  = end_mode_e'($urandom_range(0, 3));
    case (mode)
      END_TIMEOUT_ZERO: begin
        write_cfg(CFG_TIMEOUT_TICKS, '0);
        send_tick(level_tick(stage_pair()), 1'b0, '0);
      end
      END_READ_FAIL: begin
        t = level_tick(stage_pair());
        t.sample_valid = 1'b0;
        send_tick(t, 1'b0, '0);
      end
      END_COUNT_LOWERED: begin
        write_cfg(CFG_STABLE_TICKS, 20'd2);
        write_cfg(CFG_STAGE_COUNT, '0);
        while (outcome == RUN_GOING) send_tick(level_tick(stage_pair()), 1'b0, '0);
      end
      default: begin
        write_cfg(CFG_TIMEOUT_TICKS, 20'(ticks_in_stage + $urandom_range(1, 5)));
        while (outcome == RUN_GOING) send_tick(level_tick(stage_pair() ^ 2'b11), 1'b0, '0);
      end
    endcase
    repeat (HOLD_TICKS) begin
      t = in_item_t'(3'($urandom_range(0, 7)));
      send_tick(t, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    for (int i = 0; i < 1000 && stage_reports_q.size() != 0; i++) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    err_cnt += stage_reports_q.size();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
